FILE: src/alt_pkg.sv
package alt_pkg;

  // Width of the entry count and of the reported index.
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_SEARCH = 3'd2,
    KIND_CHANGE = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    IDX_PTR,
    IDX_CNT,
    IDX_POS,
    IDX_ZERO
  } idx_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DMP_RD,
    S_DMP_OUT
  } fsm_e;

  // Everything stored with an entry apart from its key.
  typedef struct packed {
    logic [63:0] name;
    logic        room;
    logic [33:0] phone;
    logic [9:0]  days;
    logic [31:0] rent;
  } rec_t;

  typedef struct packed {
    logic     load;
    logic     wr_insert;
    logic     wr_change;
    logic     wr_shift;
    logic     rd_next;
    logic     ptr_clr;
    logic     ptr_inc;
    logic     pos_save;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     emit;
    status_e  emit_status;
    idx_sel_e idx_sel;
    logic     emit_entry;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  key_hit;
    logic  at_end;
    logic  shift_more;
  } sts_t;

endpackage

FILE: src/alt_ctrl.sv
module alt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  alt_pkg::sts_t sts_i,
  output alt_pkg::cmd_t cmd_o,
  output logic          busy
);

  alt_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      alt_pkg::S_IDLE: begin
        if (start) state_d = alt_pkg::S_EXEC;
      end
      alt_pkg::S_EXEC: begin
        case (sts_i.kind)
          alt_pkg::KIND_DELETE, alt_pkg::KIND_SEARCH, alt_pkg::KIND_CHANGE: begin
            state_d = sts_i.empty ? alt_pkg::S_IDLE : alt_pkg::S_SCAN_RD;
          end
          alt_pkg::KIND_DUMP: begin
            state_d = sts_i.empty ? alt_pkg::S_IDLE : alt_pkg::S_DMP_RD;
          end
          default: state_d = alt_pkg::S_IDLE;
        endcase
      end
      alt_pkg::S_SCAN_RD: state_d = alt_pkg::S_SCAN_CMP;
      alt_pkg::S_SCAN_CMP: begin
        if (sts_i.key_hit) begin
          if (sts_i.kind == alt_pkg::KIND_DELETE && !sts_i.at_end) begin
            state_d = alt_pkg::S_SH_RD;
          end else begin
            state_d = alt_pkg::S_IDLE;
          end
        end else if (sts_i.at_end) begin
          state_d = alt_pkg::S_IDLE;
        end else begin
          state_d = alt_pkg::S_SCAN_RD;
        end
      end
      alt_pkg::S_SH_RD: state_d = alt_pkg::S_SH_WR;
      alt_pkg::S_SH_WR: begin
        state_d = sts_i.shift_more ? alt_pkg::S_SH_RD : alt_pkg::S_IDLE;
      end
      alt_pkg::S_DMP_RD: state_d = alt_pkg::S_DMP_OUT;
      alt_pkg::S_DMP_OUT: begin
        state_d = sts_i.at_end ? alt_pkg::S_IDLE : alt_pkg::S_DMP_RD;
      end
      default: state_d = alt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = alt_pkg::ST_OK;
    cmd_o.idx_sel     = alt_pkg::IDX_PTR;
    cmd_o.emit_last   = 1'b1;
    case (state_q)
      alt_pkg::S_IDLE: cmd_o.load = start;
      alt_pkg::S_EXEC: begin
        case (sts_i.kind)
          alt_pkg::KIND_INSERT: begin
            cmd_o.emit    = 1'b1;
            cmd_o.idx_sel = alt_pkg::IDX_CNT;
            if (sts_i.full) begin
              cmd_o.emit_status = alt_pkg::ST_FULL;
            end else begin
              cmd_o.wr_insert = 1'b1;
              cmd_o.cnt_inc   = 1'b1;
            end
          end
          alt_pkg::KIND_DELETE, alt_pkg::KIND_SEARCH, alt_pkg::KIND_CHANGE,
          alt_pkg::KIND_DUMP: begin
            if (sts_i.empty) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = alt_pkg::ST_EMPTY;
              cmd_o.idx_sel     = alt_pkg::IDX_ZERO;
            end else begin
              cmd_o.ptr_clr = 1'b1;
            end
          end
          default: ;
        endcase
      end
      alt_pkg::S_SCAN_CMP: begin
        if (sts_i.key_hit) begin
          case (sts_i.kind)
            alt_pkg::KIND_DELETE: begin
              if (sts_i.at_end) begin
                cmd_o.emit    = 1'b1;
                cmd_o.cnt_dec = 1'b1;
              end else begin
                cmd_o.pos_save = 1'b1;
              end
            end
            alt_pkg::KIND_CHANGE: begin
              cmd_o.wr_change = 1'b1;
              cmd_o.emit      = 1'b1;
            end
            default: cmd_o.emit = 1'b1;
          endcase
        end else if (sts_i.at_end) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = alt_pkg::ST_MISS;
          cmd_o.idx_sel     = alt_pkg::IDX_CNT;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      alt_pkg::S_SH_RD: cmd_o.rd_next = 1'b1;
      alt_pkg::S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        if (!sts_i.shift_more) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.idx_sel = alt_pkg::IDX_POS;
        end
      end
      alt_pkg::S_DMP_OUT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_entry = 1'b1;
        cmd_o.emit_last  = sts_i.at_end;
        cmd_o.ptr_inc    = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != alt_pkg::S_IDLE);

  // A new item is only taken while the machine is idle.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == alt_pkg::S_IDLE)
    else $error("item loaded while busy");

  // Every accepted item is examined in the cycle right after it is taken.
  a_exec_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == alt_pkg::S_EXEC)
    else $error("accepted item not dispatched");

  // A shift step always follows a read of the next entry.
  a_shift_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == alt_pkg::S_SH_WR |-> $past(state_q) == alt_pkg::S_SH_RD)
    else $error("shift write without read");

endmodule

FILE: src/alt_dp.sv
module alt_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  alt_pkg::cmd_t               cmd_i,
  output alt_pkg::sts_t               sts_o,
  input  logic [2:0]                  kind_i,
  input  logic [15:0]                 key_i,
  input  logic [15:0]                 new_key_i,
  input  logic [63:0]                 name_code_i,
  input  logic                        room_kind_i,
  input  logic [33:0]                 phone_i,
  input  logic [9:0]                  days_i,
  input  logic [31:0]                 rent_i,
  output logic                        valid_o,
  output logic [1:0]                  status_o,
  output logic [alt_pkg::CNT_W-1:0]   index_o,
  output logic [15:0]                 out_key_o,
  output logic [63:0]                 out_name_o,
  output logic                        out_room_kind_o,
  output logic [33:0]                 out_phone_o,
  output logic [9:0]                  out_days_o,
  output logic [31:0]                 out_rent_o,
  output logic                        last_o
);

  localparam int CW = alt_pkg::CNT_W;
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // Latched item.
  alt_pkg::kind_e kind_q;
  logic [15:0]    key_q;
  logic [15:0]    new_key_q;
  alt_pkg::rec_t  rec_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q          <= alt_pkg::kind_e'(kind_i);
      key_q           <= key_i;
      new_key_q       <= new_key_i;
      rec_q.name      <= name_code_i;
      rec_q.room      <= room_kind_i;
      rec_q.phone     <= phone_i;
      rec_q.days      <= days_i;
      rec_q.rent      <= rent_i;
    end
  end

  // Entry count, scan pointer and the position of a deleted entry.
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pos_q, pos_d;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) count_d = count_q + CW'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CW'(1);
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) ptr_d = '0;
    else if (cmd_i.ptr_inc) ptr_d = ptr_q + CW'(1);
    pos_d = cmd_i.pos_save ? ptr_q : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      pos_q   <= '0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pos_q   <= pos_d;
    end
  end

  // Storage: keys and the rest of each entry in two memories sharing addresses.
  logic [15:0]   key_mem [CAPACITY];
  alt_pkg::rec_t rec_mem [CAPACITY];
  logic [15:0]   key_rd_q;
  alt_pkg::rec_t rec_rd_q;

  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [CW-1:0]   ptr_next;
  logic            key_we;
  logic            rec_we;
  logic [15:0]     key_wd;
  alt_pkg::rec_t   rec_wd;

  assign ptr_next = ptr_q + CW'(1);
  assign rd_addr  = cmd_i.rd_next ? ptr_next[AW-1:0] : ptr_q[AW-1:0];
  assign wr_addr  = cmd_i.wr_insert ? count_q[AW-1:0] : ptr_q[AW-1:0];
  assign key_we   = cmd_i.wr_insert | cmd_i.wr_change | cmd_i.wr_shift;
  assign rec_we   = cmd_i.wr_insert | cmd_i.wr_shift;

  always_comb begin
    if (cmd_i.wr_insert) key_wd = key_q;
    else if (cmd_i.wr_change) key_wd = new_key_q;
    else key_wd = key_rd_q;
    rec_wd = cmd_i.wr_insert ? rec_q : rec_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= key_wd;
    key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[wr_addr] <= rec_wd;
    rec_rd_q <= rec_mem[rd_addr];
  end

  // Status toward the controller.
  logic [CW-1:0] ptr_next2;
  assign ptr_next2 = ptr_q + CW'(2);

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.full       = (count_q == CAP);
    sts_o.empty      = (count_q == '0);
    sts_o.key_hit    = (key_rd_q == key_q);
    sts_o.at_end     = (ptr_next == count_q);
    sts_o.shift_more = (ptr_next2 < count_q);
  end

  // Result register.
  logic                 valid_q;
  alt_pkg::status_e     status_q;
  logic [CW-1:0]        index_q;
  logic [15:0]          okey_q;
  alt_pkg::rec_t        orec_q;
  logic                 last_q;
  logic [CW-1:0]        index_d;

  always_comb begin
    case (cmd_i.idx_sel)
      alt_pkg::IDX_PTR: index_d = ptr_q;
      alt_pkg::IDX_CNT: index_d = count_q;
      alt_pkg::IDX_POS: index_d = pos_q;
      default:          index_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      index_q  <= index_d;
      last_q   <= cmd_i.emit_last;
      okey_q   <= cmd_i.emit_entry ? key_rd_q : '0;
      orec_q   <= cmd_i.emit_entry ? rec_rd_q : '0;
    end
  end

  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign index_o         = index_q;
  assign out_key_o       = okey_q;
  assign out_name_o      = orec_q.name;
  assign out_room_kind_o = orec_q.room;
  assign out_phone_o     = orec_q.phone;
  assign out_days_o      = orec_q.days;
  assign out_rent_o      = orec_q.rent;
  assign last_o          = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("entry count above capacity");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> count_q < CAP && !cmd_i.cnt_dec)
    else $error("insert into a full table");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.wr_insert, cmd_i.wr_change, cmd_i.wr_shift}))
    else $error("conflicting memory writes");

  // Only a dumped entry that is not the final one may come without last.
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !cmd_i.emit_entry |-> cmd_i.emit_last)
    else $error("plain result without last");

endmodule

FILE: src/array_list_table.sv
// Unsorted array list of up to CAPACITY entries, one command per item.
// Insert, and any command on an empty table: result emitted from the execute state and
// registered. Search and change key: a read and a compare state per entry scanned;
// delete adds a read and a write state per entry moved down. Dump: a read and an output
// state per entry, one result each. The key and entry memories have registered reads.
// Reset clears the entry count and the controller; stored entries are not cleared.
module array_list_table #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                kind_i,
  input  logic [15:0]               key_i,
  input  logic [15:0]               new_key_i,
  input  logic [63:0]               name_code_i,
  input  logic                      room_kind_i,
  input  logic [33:0]               phone_i,
  input  logic [9:0]                days_i,
  input  logic [31:0]               rent_i,
  output logic                      valid_o,
  output logic [1:0]                status_o,
  output logic [alt_pkg::CNT_W-1:0] index_o,
  output logic [15:0]               out_key_o,
  output logic [63:0]               out_name_o,
  output logic                      out_room_kind_o,
  output logic [33:0]               out_phone_o,
  output logic [9:0]                out_days_o,
  output logic [31:0]               out_rent_o,
  output logic                      last_o
);

  alt_pkg::cmd_t cmd;
  alt_pkg::sts_t sts;

  alt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  alt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .new_key_i       (new_key_i),
    .name_code_i     (name_code_i),
    .room_kind_i     (room_kind_i),
    .phone_i         (phone_i),
    .days_i          (days_i),
    .rent_i          (rent_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .index_o         (index_o),
    .out_key_o       (out_key_o),
    .out_name_o      (out_name_o),
    .out_room_kind_o (out_room_kind_o),
    .out_phone_o     (out_phone_o),
    .out_days_o      (out_days_o),
    .out_rent_o      (out_rent_o),
    .last_o          (last_o)
  );

endmodule

FILE: test/array_list_table_tb.sv
module array_list_table_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 450;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDX_W = alt_pkg::CNT_W;
  localparam logic [63:0] PHONE_SPAN = 64'd10000000000;
  localparam logic [33:0] PHONE_MAX = 34'd9999999999;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] key;
    logic [15:0] new_key;
    logic [63:0] name;
    logic        room;
    logic [33:0] phone;
    logic [9:0]  days;
    logic [31:0] rent;
    logic        hold_for_idle;
  } table_cmd_t;

  typedef struct packed {
    logic [15:0] key;
    logic [63:0] name;
    logic        room;
    logic [33:0] phone;
    logic [9:0]  days;
    logic [31:0] rent;
  } row_t;

  typedef struct packed {
    alt_pkg::status_e  status;
    logic [IDX_W-1:0]  index;
    row_t              row;
    logic              last;
  } table_result_t;

  typedef enum int {
    MODE_FILL,
    MODE_MIXED,
    MODE_DRAIN
  } gen_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        kind_i = '0;
  logic [15:0]       key_i = '0;
  logic [15:0]       new_key_i = '0;
  logic [63:0]       name_code_i = '0;
  logic              room_kind_i = 1'b0;
  logic [33:0]       phone_i = '0;
  logic [9:0]        days_i = '0;
  logic [31:0]       rent_i = '0;
  logic              valid_o;
  logic [1:0]        status_o;
  logic [IDX_W-1:0]  index_o;
  logic [15:0]       out_key_o;
  logic [63:0]       out_name_o;
  logic              out_room_kind_o;
  logic [33:0]       out_phone_o;
  logic [9:0]        out_days_o;
  logic [31:0]       out_rent_o;
  logic              last_o;

  table_cmd_t    cmd_queue[$];
  table_cmd_t    cur_cmd;
  table_result_t due_results[$];
  table_result_t want;
  row_t          rows[TABLE_DEPTH];
  int            row_count = 0;
  logic [15:0]   gen_keys[$];
  logic [15:0]   key_pool[8];
  int            err_count = 0;
  int            result_no = 0;
  int            cycle_count = 0;
  int            gap_left = 0;
  int            burst_left = 0;

  array_list_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .new_key_i      (new_key_i),
    .name_code_i    (name_code_i),
    .room_kind_i    (room_kind_i),
    .phone_i        (phone_i),
    .days_i         (days_i),
    .rent_i         (rent_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .index_o        (index_o),
    .out_key_o      (out_key_o),
    .out_name_o     (out_name_o),
    .out_room_kind_o(out_room_kind_o),
    .out_phone_o    (out_phone_o),
    .out_days_o     (out_days_o),
    .out_rent_o     (out_rent_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR cycle %0d result %0d: %s", cycle_count, result_no, msg);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is %h, expected %h", field, got, exp_val));
  endtask

  function automatic int first_row_with(input logic [15:0] k);
    int i;
    for (i = 0; i < row_count; i++) begin
      if (rows[i].key == k) return i;
    end
    return row_count;
  endfunction

  // Applies one command to the table copy and queues the results it yields.
  task automatic compute_table_results(input table_cmd_t c);
    table_result_t r;
    int pos;
    int i;
    r = '0;
    r.last = 1'b1;
    case (c.kind)
      alt_pkg::KIND_INSERT: begin
        r.index = IDX_W'(row_count);
        if (row_count >= TABLE_DEPTH) begin
          r.status = alt_pkg::ST_FULL;
        end else begin
          rows[row_count] = '{key: c.key, name: c.name, room: c.room,
                              phone: c.phone, days: c.days, rent: c.rent};
          row_count++;
        end
        due_results.push_back(r);
      end
      alt_pkg::KIND_DELETE, alt_pkg::KIND_SEARCH, alt_pkg::KIND_CHANGE: begin
        if (row_count == 0) begin
          r.status = alt_pkg::ST_EMPTY;
        end else begin
          pos = first_row_with(c.key);
          r.index = IDX_W'(pos);
          if (pos >= row_count) begin
            r.status = alt_pkg::ST_MISS;
          end else if (c.kind == alt_pkg::KIND_DELETE) begin
            for (i = pos; i < row_count - 1; i++) rows[i] = rows[i + 1];
            row_count--;
          end else if (c.kind == alt_pkg::KIND_CHANGE) begin
            rows[pos].key = c.new_key;
          end
        end
        due_results.push_back(r);
      end
      alt_pkg::KIND_DUMP: begin
        if (row_count == 0) begin
          r.status = alt_pkg::ST_EMPTY;
          due_results.push_back(r);
        end else begin
          for (i = 0; i < row_count; i++) begin
            r.index = IDX_W'(i);
            r.row = rows[i];
            r.last = (i == row_count - 1);
            due_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sender: bursts of items separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (start && !busy) compute_table_results(cur_cmd);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     (!cmd_queue[0].hold_for_idle || due_results.size() == 0)) begin
          cur_cmd = cmd_queue.pop_front();
          kind_i <= cur_cmd.kind;
          key_i <= cur_cmd.key;
          new_key_i <= cur_cmd.new_key;
          name_code_i <= cur_cmd.name;
          room_kind_i <= cur_cmd.room;
          phone_i <= cur_cmd.phone;
          days_i <= cur_cmd.days;
          rent_i <= cur_cmd.rent;
          start <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d index %0d",
                                  status_o, index_o));
      end else begin
        want = due_results.pop_front();
        check_field("status", 64'(status_o), 64'(want.status));
        check_field("index", 64'(index_o), 64'(want.index));
        check_field("out_key", 64'(out_key_o), 64'(want.row.key));
        check_field("out_name", out_name_o, want.row.name);
        check_field("out_room_kind", 64'(out_room_kind_o), 64'(want.row.room));
        check_field("out_phone", 64'(out_phone_o), 64'(want.row.phone));
        check_field("out_days", 64'(out_days_o), 64'(want.row.days));
        check_field("out_rent", 64'(out_rent_o), 64'(want.row.rent));
        check_field("last", 64'(last_o), 64'(want.last));
      end
      result_no++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Keys the generator believes are stored, so lookups mostly hit.
  task automatic queue_command(input table_cmd_t c);
    int i;
    bit found;
    found = 1'b0;
    case (c.kind)
      alt_pkg::KIND_INSERT: if (gen_keys.size() < TABLE_DEPTH) gen_keys.push_back(c.key);
      alt_pkg::KIND_DELETE, alt_pkg::KIND_CHANGE: begin
        for (i = 0; i < gen_keys.size() && !found; i++) begin
          if (gen_keys[i] == c.key) begin
            found = 1'b1;
            if (c.kind == alt_pkg::KIND_DELETE) gen_keys.delete(i);
            else gen_keys[i] = c.new_key;
          end
        end
      end
      default: ;
    endcase
    cmd_queue.push_back(c);
  endtask

  function automatic logic [15:0] pick_key(input bit lookup);
    int sel;
    sel = $urandom_range(0, 9);
    if (lookup && gen_keys.size() != 0 && sel < 8)
      return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    if (sel < 6) return key_pool[3'($urandom_range(0, 7))];
    return 16'($urandom);
  endfunction

  function automatic table_cmd_t random_cmd(input logic [2:0] kind, input logic [15:0] k);
    table_cmd_t c;
    c.kind = kind;
    c.key = k;
    c.new_key = ($urandom_range(0, 1) == 0) ? key_pool[3'($urandom_range(0, 7))]
                                            : 16'($urandom);
    c.name = {$urandom, $urandom};
    c.room = 1'($urandom_range(0, 1));
    c.phone = 34'({$urandom, $urandom} % PHONE_SPAN);
    c.days = 10'($urandom_range(0, 1023));
    c.rent = $urandom;
    c.hold_for_idle = 1'b0;
    return c;
  endfunction

  function automatic logic [2:0] choose_kind(input gen_mode_e mode);
    int p;
    p = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (p < 86) return alt_pkg::KIND_INSERT;
        if (p < 90) return alt_pkg::KIND_DELETE;
        if (p < 94) return alt_pkg::KIND_SEARCH;
        if (p < 96) return alt_pkg::KIND_CHANGE;
        if (p < 98) return alt_pkg::KIND_DUMP;
      end
      MODE_DRAIN: begin
        if (p < 4) return alt_pkg::KIND_INSERT;
        if (p < 82) return alt_pkg::KIND_DELETE;
        if (p < 89) return alt_pkg::KIND_SEARCH;
        if (p < 94) return alt_pkg::KIND_CHANGE;
        if (p < 98) return alt_pkg::KIND_DUMP;
      end
      default: begin
        if (p < 20) return alt_pkg::KIND_INSERT;
        if (p < 40) return alt_pkg::KIND_DELETE;
        if (p < 60) return alt_pkg::KIND_SEARCH;
        if (p < 80) return alt_pkg::KIND_CHANGE;
        if (p < 97) return alt_pkg::KIND_DUMP;
      end
    endcase
    // Codes above the dump are not commands and must be ignored.
    return 3'(alt_pkg::KIND_DUMP + $urandom_range(1, 3));
  endfunction

  initial begin
    table_cmd_t c;
    gen_mode_e  mode;
    logic [2:0] kind;
    int         made;
    int         extra;
    int         mixed_left;
    bit         new_phase;

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = 16'($urandom);

    // Directed part: empty table, unknown codes, extremes, duplicates.
    queue_command(random_cmd(alt_pkg::KIND_SEARCH, 16'h0000));
    queue_command(random_cmd(alt_pkg::KIND_DELETE, 16'hFFFF));
    queue_command(random_cmd(alt_pkg::KIND_CHANGE, 16'h1234));
    queue_command(random_cmd(alt_pkg::KIND_DUMP, 16'h0000));
    queue_command(random_cmd(alt_pkg::KIND_DUMP + 3'd1, 16'h0000));
    c = '0;
    c.kind = alt_pkg::KIND_INSERT;
    queue_command(c);
    c = '{kind: alt_pkg::KIND_INSERT, key: 16'hFFFF, new_key: 16'hFFFF, name: '1,
          room: 1'b1, phone: PHONE_MAX, days: 10'h3FF, rent: '1, hold_for_idle: 1'b0};
    queue_command(c);
    queue_command(random_cmd(alt_pkg::KIND_INSERT, 16'h1234));
    queue_command(random_cmd(alt_pkg::KIND_INSERT, 16'h1234));
    queue_command(random_cmd(alt_pkg::KIND_SEARCH, 16'h1234));
    queue_command(random_cmd(alt_pkg::KIND_SEARCH, 16'h5A5A));
    c = random_cmd(alt_pkg::KIND_CHANGE, 16'h1234);
    c.new_key = 16'h0000;
    queue_command(c);
    c = random_cmd(alt_pkg::KIND_CHANGE, 16'h1234);
    c.new_key = 16'hFFFF;
    queue_command(c);
    queue_command(random_cmd(alt_pkg::KIND_CHANGE, 16'h5A5A));
    c = random_cmd(alt_pkg::KIND_DUMP, 16'h0000);
    c.hold_for_idle = 1'b1;
    queue_command(c);
    queue_command(random_cmd(alt_pkg::KIND_DELETE, 16'h0000));
    queue_command(random_cmd(alt_pkg::KIND_DELETE, 16'h5A5A));
    queue_command(random_cmd(alt_pkg::KIND_DELETE, 16'hFFFF));
    queue_command(random_cmd(alt_pkg::KIND_DUMP + 3'd3, 16'h0000));
    queue_command(random_cmd(alt_pkg::KIND_DUMP, 16'h0000));
    queue_command(random_cmd(alt_pkg::KIND_DELETE, 16'hFFFF));
    queue_command(random_cmd(alt_pkg::KIND_DELETE, 16'h0000));
    queue_command(random_cmd(alt_pkg::KIND_SEARCH, 16'h0000));
    queue_command(random_cmd(alt_pkg::KIND_DUMP, 16'h0000));

    // Random part: fill to beyond capacity, mix, then drain to empty, repeated.
    made = 0;
    extra = 0;
    mixed_left = 0;
    mode = MODE_FILL;
    new_phase = 1'b1;
    while (made < RANDOM_ITEMS) begin
      kind = choose_kind(mode);
      c = random_cmd(kind, pick_key(kind != alt_pkg::KIND_INSERT));
      c.hold_for_idle = new_phase;
      new_phase = 1'b0;
      queue_command(c);
      if (kind <= alt_pkg::KIND_DUMP) made++;
      case (mode)
        MODE_FILL: begin
          if (gen_keys.size() == TABLE_DEPTH) extra++;
          if (extra > 6) begin
            mode = MODE_MIXED;
            mixed_left = 15;
            new_phase = 1'b1;
          end
        end
        MODE_MIXED: begin
          mixed_left--;
          if (mixed_left == 0) begin
            mode = MODE_DRAIN;
            extra = 0;
            new_phase = 1'b1;
          end
        end
        default: begin
          if (gen_keys.size() == 0) extra++;
          if (extra > 3) begin
            mode = MODE_FILL;
            extra = 0;
            new_phase = 1'b1;
          end
        end
      endcase
    end

    while (cmd_queue.size() != 0 || start || due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/alt_pkg.sv
src/alt_ctrl.sv
src/alt_dp.sv
src/array_list_table.sv
test/array_list_table_tb.sv
